// ===== sv/fts_pkg.sv =====
package fts_pkg;

    // sequencer phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_ARMED = 5'b00010,
        PH_REC   = 5'b00100,
        PH_SAVE  = 5'b01000,
        PH_FIN   = 5'b10000
    } phase_t;

    // external mode code
    typedef logic [2:0] mode_t;
    localparam mode_t MODE_IDLE  = 3'd0;
    localparam mode_t MODE_ARMED = 3'd1;
    localparam mode_t MODE_REC   = 3'd2;
    localparam mode_t MODE_SAVE  = 3'd3;
    localparam mode_t MODE_FIN   = 3'd4;

    // item function codes
    typedef logic [1:0] func_t;
    localparam func_t FUNC_SAMPLE = 2'd0;
    localparam func_t FUNC_ARM    = 2'd1;
    localparam func_t FUNC_ABORT  = 2'd2;

    // end reason codes
    typedef logic [1:0] reason_t;
    localparam reason_t REASON_NONE = 2'd0;
    localparam reason_t REASON_LOW  = 2'd1;
    localparam reason_t REASON_TIME = 2'd2;

    // configuration register indexes
    typedef logic [2:0] cfg_index_t;
    localparam cfg_index_t CFG_TRIGGER_LEVEL = 3'd0;
    localparam cfg_index_t CFG_STOP_LEVEL    = 3'd1;
    localparam cfg_index_t CFG_MAX_DURATION  = 3'd2;
    localparam cfg_index_t CFG_TRIGGER_RUN   = 3'd3;
    localparam cfg_index_t CFG_STOP_RUN      = 3'd4;

    // run counters
    localparam int HIGH_RUN_BITS = 8;
    localparam int LOW_RUN_BITS  = 16;
    typedef logic [HIGH_RUN_BITS-1:0] high_run_t;
    typedef logic [LOW_RUN_BITS-1:0]  low_run_t;
    localparam high_run_t TRIGGER_RUN_RESET = 8'd3;
    localparam low_run_t  STOP_RUN_RESET    = 16'd40;

    // per-item status flags
    typedef struct packed {
        logic    recording;
        logic    capture_valid;
        logic    started;
        reason_t end_reason;
        logic    save_request;
        logic    arm_accepted;
    } flags_t;

    function automatic mode_t phase_mode(input phase_t p);
        mode_t m;
        unique case (p)
            PH_IDLE:  m = MODE_IDLE;
            PH_ARMED: m = MODE_ARMED;
            PH_REC:   m = MODE_REC;
            PH_SAVE:  m = MODE_SAVE;
            PH_FIN:   m = MODE_FIN;
            default:  m = MODE_IDLE;
        endcase
        return m;
    endfunction

endpackage

// ===== sv/fts_step.sv =====
module fts_step #(
    parameter int FORCE_BITS = 24,
    parameter int TIME_BITS  = 32
) (
    input  fts_pkg::func_t                func,
    input  logic signed [FORCE_BITS-1:0]  force_in,
    input  logic [TIME_BITS-1:0]          time_in,
    input  logic signed [FORCE_BITS-1:0]  trigger_level,
    input  logic signed [FORCE_BITS-1:0]  stop_level,
    input  logic [TIME_BITS-1:0]          max_duration,
    input  fts_pkg::high_run_t            trigger_run,
    input  fts_pkg::low_run_t             stop_run,
    input  fts_pkg::phase_t               phase_cur,
    input  fts_pkg::high_run_t            high_run_cur,
    input  fts_pkg::low_run_t             low_run_cur,
    input  logic signed [FORCE_BITS-1:0]  peak_cur,
    input  logic signed [FORCE_BITS-1:0]  last_cur,
    input  logic [TIME_BITS-1:0]          start_cur,
    output fts_pkg::phase_t               phase_nxt,
    output fts_pkg::high_run_t            high_run_nxt,
    output fts_pkg::low_run_t             low_run_nxt,
    output logic signed [FORCE_BITS-1:0]  peak_nxt,
    output logic signed [FORCE_BITS-1:0]  last_nxt,
    output logic [TIME_BITS-1:0]          start_nxt,
    output logic [TIME_BITS-1:0]          elapsed,
    output fts_pkg::flags_t               flags
);

    fts_pkg::high_run_t     high_inc;
    fts_pkg::low_run_t      low_inc;
    logic [TIME_BITS-1:0]   elapsed_full;

    // saturating run counters
    assign high_inc = (high_run_cur == '1) ? high_run_cur : high_run_cur + 1'b1;
    assign low_inc  = (low_run_cur == '1) ? low_run_cur : low_run_cur + 1'b1;
    assign elapsed_full = time_in - start_cur;

    always_comb
    begin
        phase_nxt    = phase_cur;
        high_run_nxt = high_run_cur;
        low_run_nxt  = low_run_cur;
        peak_nxt     = peak_cur;
        last_nxt     = last_cur;
        start_nxt    = start_cur;
        elapsed      = '0;
        flags        = '0;

        unique case (func)
            fts_pkg::FUNC_ARM:
            begin
                if (phase_cur == fts_pkg::PH_IDLE)
                begin
                    peak_nxt           = '0;
                    high_run_nxt       = '0;
                    low_run_nxt        = '0;
                    phase_nxt          = fts_pkg::PH_ARMED;
                    flags.arm_accepted = 1'b1;
                end
            end
            fts_pkg::FUNC_ABORT:
            begin
                phase_nxt = fts_pkg::PH_FIN;
            end
            fts_pkg::FUNC_SAMPLE:
            begin
                last_nxt = force_in;
                if (force_in > peak_cur)
                    peak_nxt = force_in;
                unique case (phase_cur)
                    fts_pkg::PH_ARMED:
                    begin
                        if (force_in >= trigger_level)
                        begin
                            high_run_nxt = high_inc;
                            if (high_inc >= trigger_run)
                            begin
                                flags.started = 1'b1;
                                peak_nxt      = force_in;
                                high_run_nxt  = '0;
                                low_run_nxt   = '0;
                                start_nxt     = time_in;
                                phase_nxt     = fts_pkg::PH_REC;
                            end
                        end
                        else
                        begin
                            high_run_nxt = '0;
                        end
                    end
                    fts_pkg::PH_REC:
                    begin
                        elapsed             = elapsed_full;
                        flags.capture_valid = 1'b1;
                        // time limit wins over the low run
                        if (elapsed_full >= max_duration)
                        begin
                            flags.end_reason = fts_pkg::REASON_TIME;
                            phase_nxt        = fts_pkg::PH_SAVE;
                        end
                        else if (force_in < stop_level)
                        begin
                            low_run_nxt = low_inc;
                            if (low_inc >= stop_run)
                            begin
                                flags.end_reason = fts_pkg::REASON_LOW;
                                phase_nxt        = fts_pkg::PH_SAVE;
                            end
                        end
                        else
                        begin
                            low_run_nxt = '0;
                        end
                    end
                    fts_pkg::PH_SAVE:
                    begin
                        flags.save_request = 1'b1;
                        phase_nxt          = fts_pkg::PH_FIN;
                    end
                    fts_pkg::PH_FIN:
                    begin
                        phase_nxt = fts_pkg::PH_IDLE;
                    end
                    default:
                    begin
                        phase_nxt = phase_cur;
                    end
                endcase
            end
            default:
            begin
                phase_nxt = phase_cur;
            end
        endcase

        flags.recording = (phase_nxt == fts_pkg::PH_REC);
    end

endmodule

// ===== sv/force_triggered_capture_sequencer.sv =====
// force triggered capture sequencer
//
// input channel (in_valid / in_ready): one transfer per item, func selects a
// force sample, an arm command or an abort command; time_us is the sample
// timestamp in microseconds. output channel (out_valid / out_ready): exactly
// one result transfer per input item, in order, carrying the latest force,
// the running peak, the mode after the item and the per-item flags.
// config channel (cfg_valid / cfg_ready): cfg_ready is always high; a
// transfer writes register cfg_index with cfg_data (0 trigger level, 1 stop
// level, 2 max duration, 3 trigger run length, 4 stop run length). write
// only while no item is in flight.
// an item taken moves from the input register to the result register and
// shows at out_valid. throughput: one item per cycle while the result
// register is not stalled; the sequencer state is updated in a single pass
// of compare, saturating count and one subtract between those registers.
// reset: mode idle, counters, peak and last force cleared, config registers
// at their defaults, both pipeline slots empty.
// stall: when out_ready is low the result register holds; the input
// register still takes one more item, then in_ready drops until the result
// is taken.
module force_triggered_capture_sequencer #(
    parameter int FORCE_BITS = 24,
    parameter int TIME_BITS  = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  fts_pkg::cfg_index_t           cfg_index,
    // config data is as wide as the widest register
    input  logic [((TIME_BITS > FORCE_BITS) ? TIME_BITS : FORCE_BITS)-1:0] cfg_data,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  fts_pkg::func_t                func,
    input  logic signed [FORCE_BITS-1:0]  force_req,
    input  logic [TIME_BITS-1:0]          time_us,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [FORCE_BITS-1:0]  force_now,
    output logic signed [FORCE_BITS-1:0]  peak,
    output fts_pkg::mode_t                mode,
    output logic                          recording,
    output logic                          capture_valid,
    output logic [TIME_BITS-1:0]          elapsed_us,
    output logic                          started,
    output fts_pkg::reason_t              end_reason,
    output logic                          save_request,
    output logic                          arm_accepted
);

    // configuration registers
    logic signed [FORCE_BITS-1:0]  trigger_level_reg;
    logic signed [FORCE_BITS-1:0]  stop_level_reg;
    logic [TIME_BITS-1:0]          max_duration_reg;
    fts_pkg::high_run_t            trigger_run_reg;
    fts_pkg::low_run_t             stop_run_reg;

    // input register slot
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    fts_pkg::func_t                s1_func_reg;
    logic signed [FORCE_BITS-1:0]  s1_force_reg;
    logic [TIME_BITS-1:0]          s1_time_reg;

    // sequencer state
    fts_pkg::phase_t               phase_reg;
    fts_pkg::phase_t               phase_next;
    fts_pkg::high_run_t            high_run_reg;
    fts_pkg::high_run_t            high_run_next;
    fts_pkg::low_run_t             low_run_reg;
    fts_pkg::low_run_t             low_run_next;
    logic signed [FORCE_BITS-1:0]  peak_reg;
    logic signed [FORCE_BITS-1:0]  peak_next;
    logic signed [FORCE_BITS-1:0]  last_reg;
    logic signed [FORCE_BITS-1:0]  last_next;
    logic [TIME_BITS-1:0]          start_reg;
    logic [TIME_BITS-1:0]          start_next;

    // result register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [TIME_BITS-1:0]          elapsed_next;
    fts_pkg::flags_t               flags_next;
    fts_pkg::flags_t               flags_reg;
    fts_pkg::mode_t                mode_reg;
    logic signed [FORCE_BITS-1:0]  force_now_reg;
    logic signed [FORCE_BITS-1:0]  peak_out_reg;
    logic [TIME_BITS-1:0]          elapsed_reg;

    logic                          in_xfer;
    logic                          advance;
    logic                          commit;

    // result slot frees up when empty or being taken
    assign advance  = !out_valid_reg || out_ready;
    assign commit   = advance && s1_valid_reg;
    assign in_ready = !s1_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (in_xfer)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        out_valid_next = advance ? s1_valid_reg : out_valid_reg;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_level_reg <= FORCE_BITS'(1000);
            stop_level_reg    <= FORCE_BITS'(500);
            max_duration_reg  <= TIME_BITS'(10000000);
            trigger_run_reg   <= fts_pkg::TRIGGER_RUN_RESET;
            stop_run_reg      <= fts_pkg::STOP_RUN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fts_pkg::CFG_TRIGGER_LEVEL: trigger_level_reg <= cfg_data[FORCE_BITS-1:0];
                fts_pkg::CFG_STOP_LEVEL:    stop_level_reg    <= cfg_data[FORCE_BITS-1:0];
                fts_pkg::CFG_MAX_DURATION:  max_duration_reg  <= cfg_data[TIME_BITS-1:0];
                fts_pkg::CFG_TRIGGER_RUN:
                    trigger_run_reg <= cfg_data[fts_pkg::HIGH_RUN_BITS-1:0];
                fts_pkg::CFG_STOP_RUN:
                    stop_run_reg <= cfg_data[fts_pkg::LOW_RUN_BITS-1:0];
                default:
                begin
                    // unknown index, write dropped
                    stop_run_reg <= stop_run_reg;
                end
            endcase
        end
    end

    // handshake control and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= fts_pkg::PH_IDLE;
            high_run_reg  <= '0;
            low_run_reg   <= '0;
            peak_reg      <= '0;
            last_reg      <= '0;
            start_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                phase_reg    <= phase_next;
                high_run_reg <= high_run_next;
                low_run_reg  <= low_run_next;
                peak_reg     <= peak_next;
                last_reg     <= last_next;
                start_reg    <= start_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_func_reg  <= func;
            s1_force_reg <= force_req;
            s1_time_reg  <= time_us;
        end
        if (commit)
        begin
            force_now_reg <= last_next;
            peak_out_reg  <= peak_next;
            mode_reg      <= fts_pkg::phase_mode(phase_next);
            elapsed_reg   <= elapsed_next;
            flags_reg     <= flags_next;
        end
    end

    fts_step #(
        .FORCE_BITS (FORCE_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_step (
        .func          (s1_func_reg),
        .force_in      (s1_force_reg),
        .time_in       (s1_time_reg),
        .trigger_level (trigger_level_reg),
        .stop_level    (stop_level_reg),
        .max_duration  (max_duration_reg),
        .trigger_run   (trigger_run_reg),
        .stop_run      (stop_run_reg),
        .phase_cur     (phase_reg),
        .high_run_cur  (high_run_reg),
        .low_run_cur   (low_run_reg),
        .peak_cur      (peak_reg),
        .last_cur      (last_reg),
        .start_cur     (start_reg),
        .phase_nxt     (phase_next),
        .high_run_nxt  (high_run_next),
        .low_run_nxt   (low_run_next),
        .peak_nxt      (peak_next),
        .last_nxt      (last_next),
        .start_nxt     (start_next),
        .elapsed       (elapsed_next),
        .flags         (flags_next)
    );

    assign out_valid     = out_valid_reg;
    assign force_now     = force_now_reg;
    assign peak          = peak_out_reg;
    assign mode          = mode_reg;
    assign recording     = flags_reg.recording;
    assign capture_valid = flags_reg.capture_valid;
    assign elapsed_us    = elapsed_reg;
    assign started       = flags_reg.started;
    assign end_reason    = flags_reg.end_reason;
    assign save_request  = flags_reg.save_request;
    assign arm_accepted  = flags_reg.arm_accepted;

`ifndef SYNTHESIS
    // a start always lands in recording, with peak reloaded to the sample
    a_start_recording: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && started) |->
        (recording && mode == fts_pkg::MODE_REC && peak == force_now))
        else $error("start without entering recording");

    // elapsed time only reported on captured samples
    a_elapsed_gated: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !capture_valid) |-> (elapsed_us == '0))
        else $error("elapsed time on uncaptured item");

    // an end of recording always moves to the saving step
    a_end_to_save: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_reason != fts_pkg::REASON_NONE) |->
        (capture_valid && mode == fts_pkg::MODE_SAVE))
        else $error("recording ended without saving step");

    // save request only on the step into finished
    a_save_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && save_request) |-> (mode == fts_pkg::MODE_FIN && !recording))
        else $error("save request outside saving step");

    // state only moves when a result is loaded
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(commit) |-> $stable(phase_reg))
        else $error("phase changed without an item");
`endif

endmodule
